>>> hdl/cascaded_biquad_band_filter_top_macros.svh
// Assertion macros for the checker file.
`ifndef CASCADED_BIQUAD_BAND_FILTER_TOP_MACROS_SVH
`define CASCADED_BIQUAD_BAND_FILTER_TOP_MACROS_SVH

// Implication to the next cycle, off while reset is high.
`define CBBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication to the next cycle, checked during reset too.
`define CBBF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cbbf_pkg.sv
`default_nettype none
package cbbf_pkg;

  localparam int MAX_STAGES_DEF     = 4;
  localparam int CHANNELS_DEF       = 2;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 22;

  localparam int COEF_BITS       = 25;
  localparam int STATE_BITS      = 40;
  localparam int STATE_FRAC_BITS = 16;
  localparam int STAGE_CNT_BITS  = 3;
  localparam int CFG_INDEX_BITS  = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BAND_MODE   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STAGE_COUNT = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_GAIN    = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_FB1     = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_FB2     = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_GAIN   = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_FB1    = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_FB2    = 4'd7;

  // Datapath step for one section.
  localparam logic [2:0] STEP_NONE   = 3'd0;
  localparam logic [2:0] STEP_READ   = 3'd1;
  localparam logic [2:0] STEP_OUT_Y  = 3'd2;
  localparam logic [2:0] STEP_FB1    = 3'd3;
  localparam logic [2:0] STEP_STATE1 = 3'd4;
  localparam logic [2:0] STEP_STATE2 = 3'd5;

  typedef struct packed {
    logic       start;
    logic [2:0] step;
    logic       chain;
    logic       to_high;
    logic       finish;
  } cbbf_cmd_t;

  typedef struct packed {
    logic out_free;
  } cbbf_status_t;

endpackage
`default_nettype wire

>>> hdl/cascaded_biquad_band_filter_top.sv
`default_nettype none
// Two-channel cascaded biquad band filter. Each request carries a channel tag
// and a signed sample; one filtered, saturated sample comes back per request.
// Sections run one at a time on a single shared multiplier (three products
// per section) and a state memory with one read and one write port; an item
// runs the active stages of the low-pass chain and then of the high-pass
// chain before the next acceptance. A finished result waits in the output
// register, so the next request can start while it is held; a request that
// finishes while the previous result is still stalled waits until that result
// leaves. State memory reads as zero after reset without a clearing pass.
// Write coefficients only while no request is in flight; the configuration
// port is always ready.
module cascaded_biquad_band_filter_top import cbbf_pkg::*; #(
  parameter int MAX_STAGES     = MAX_STAGES_DEF,
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          channel_id,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          channel_out,
  output      logic signed [SAMPLE_BITS-1:0] sample_out,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [COEF_BITS-1:0]          cfg_data
);

  localparam int STG_IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  logic                        band_mode;
  logic [STAGE_CNT_BITS-1:0]   stage_count;
  logic signed [COEF_BITS-1:0] low_gain;
  logic signed [COEF_BITS-1:0] low_fb1;
  logic signed [COEF_BITS-1:0] low_fb2;
  logic signed [COEF_BITS-1:0] high_gain;
  logic signed [COEF_BITS-1:0] high_fb1;
  logic signed [COEF_BITS-1:0] high_fb2;

  cbbf_cmd_t             cmd;
  cbbf_status_t          status;
  logic [STG_IDX_W-1:0]  stage_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_mode   <= 1'b0;
      stage_count <= STAGE_CNT_BITS'(1);
      low_gain    <= '0;
      low_fb1     <= '0;
      low_fb2     <= '0;
      high_gain   <= '0;
      high_fb1    <= '0;
      high_fb2    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAND_MODE:   band_mode   <= cfg_data[0];
        REG_STAGE_COUNT: stage_count <= cfg_data[STAGE_CNT_BITS-1:0];
        REG_LOW_GAIN:    low_gain    <= $signed(cfg_data);
        REG_LOW_FB1:     low_fb1     <= $signed(cfg_data);
        REG_LOW_FB2:     low_fb2     <= $signed(cfg_data);
        REG_HIGH_GAIN:   high_gain   <= $signed(cfg_data);
        REG_HIGH_FB1:    high_fb1    <= $signed(cfg_data);
        REG_HIGH_FB2:    high_fb2    <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  cbbf_controller #(
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stage_count (stage_count),
    .status      (status),
    .cmd         (cmd),
    .stage_idx   (stage_idx)
  );

  cbbf_datapath #(
    .MAX_STAGES     (MAX_STAGES),
    .CHANNELS       (CHANNELS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stage_idx   (stage_idx),
    .status      (status),
    .band_mode   (band_mode),
    .low_gain    (low_gain),
    .low_fb1     (low_fb1),
    .low_fb2     (low_fb2),
    .high_gain   (high_gain),
    .high_fb1    (high_fb1),
    .high_fb2    (high_fb2),
    .channel_id  (channel_id),
    .sample_in   (sample_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .sample_out  (sample_out)
  );

endmodule
`default_nettype wire

>>> hdl/cbbf_controller.sv
`default_nettype none
module cbbf_controller import cbbf_pkg::*; #(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  localparam int STG_IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [STAGE_CNT_BITS-1:0] stage_count,
  input  wire cbbf_status_t              status,
  output      cbbf_cmd_t                 cmd,
  output      logic [STG_IDX_W-1:0]      stage_idx
);

  localparam int STG_W = $clog2(MAX_STAGES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_OUT_Y  = 3'd2;
  localparam logic [2:0] S_FB1    = 3'd3;
  localparam logic [2:0] S_STATE1 = 3'd4;
  localparam logic [2:0] S_STATE2 = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic             chain;
  logic             chain_next;
  logic [STG_W-1:0] stage;
  logic [STG_W-1:0] stage_next;
  logic [STG_W-1:0] active;
  logic             last_stage;

  always_comb begin
    if (stage_count == '0) begin
      active = STG_W'(1);
    end else if (int'(stage_count) > MAX_STAGES) begin
      active = STG_W'(MAX_STAGES);
    end else begin
      active = STG_W'(stage_count);
    end
  end

  assign last_stage = (stage == active - STG_W'(1));

  always_comb begin
    state_next = state;
    chain_next = chain;
    stage_next = stage;
    cmd        = '0;
    cmd.chain  = chain;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          chain_next = 1'b0;
          stage_next = '0;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.step   = STEP_READ;
        state_next = S_OUT_Y;
      end
      S_OUT_Y: begin
        cmd.step   = STEP_OUT_Y;
        state_next = S_FB1;
      end
      S_FB1: begin
        cmd.step   = STEP_FB1;
        state_next = S_STATE1;
      end
      S_STATE1: begin
        cmd.step   = STEP_STATE1;
        state_next = S_STATE2;
      end
      S_STATE2: begin
        cmd.step = STEP_STATE2;
        if (!last_stage) begin
          stage_next = stage + STG_W'(1);
          state_next = S_READ;
        end else if (!chain) begin
          // switch over to the high-pass chain
          cmd.to_high = 1'b1;
          chain_next  = 1'b1;
          stage_next  = '0;
          state_next  = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chain <= 1'b0;
      stage <= '0;
    end else begin
      state <= state_next;
      chain <= chain_next;
      stage <= stage_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign stage_idx = stage[STG_IDX_W-1:0];

endmodule
`default_nettype wire

>>> hdl/cbbf_datapath.sv
`default_nettype none
module cbbf_datapath import cbbf_pkg::*; #(
  parameter int MAX_STAGES     = MAX_STAGES_DEF,
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int STG_IDX_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cbbf_cmd_t                     cmd,
  input  wire logic [STG_IDX_W-1:0]          stage_idx,
  output      cbbf_status_t                  status,
  input  wire logic                          band_mode,
  input  wire logic signed [COEF_BITS-1:0]   low_gain,
  input  wire logic signed [COEF_BITS-1:0]   low_fb1,
  input  wire logic signed [COEF_BITS-1:0]   low_fb2,
  input  wire logic signed [COEF_BITS-1:0]   high_gain,
  input  wire logic signed [COEF_BITS-1:0]   high_fb1,
  input  wire logic signed [COEF_BITS-1:0]   high_fb2,
  input  wire logic                          channel_id,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          channel_out,
  output      logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int SLOTS  = CHANNELS * MAX_STAGES * 2;
  localparam int DEPTH  = 2 * SLOTS;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int UP     = (COEF_FRAC_BITS >= STATE_FRAC_BITS) ?
                          COEF_FRAC_BITS - STATE_FRAC_BITS : 0;
  localparam int DN     = (COEF_FRAC_BITS >= STATE_FRAC_BITS) ?
                          0 : STATE_FRAC_BITS - COEF_FRAC_BITS;
  localparam int ACC_W  = ((PROD_W + 1 > STATE_BITS + UP) ?
                          PROD_W + 1 : STATE_BITS + UP) + 3;
  localparam int WIDE_W = ACC_W + DN;
  localparam int UP_RND = (UP > 0) ? UP - 1 : 0;
  localparam int DN_RND = (DN > 0) ? DN - 1 : 0;

  localparam logic signed [ACC_W-1:0] RND_CF = $signed(ACC_W'(1) << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] RND_UP = (UP > 0) ? $signed(ACC_W'(1) << UP_RND) : '0;
  localparam logic signed [ACC_W-1:0] RND_DN = (DN > 0) ? $signed(ACC_W'(1) << DN_RND) : '0;
  localparam logic signed [ACC_W-1:0] Y_HI =
    $signed({{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] Y_LO = ~Y_HI;
  localparam logic signed [WIDE_W-1:0] M_HI =
    $signed({{(WIDE_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}});
  localparam logic signed [WIDE_W-1:0] M_LO = ~M_HI;
  localparam logic signed [SAMPLE_BITS:0] S_HI =
    $signed({2'b00, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [SAMPLE_BITS:0] S_LO = ~S_HI;

  logic                          chan_r;
  logic signed [SAMPLE_BITS-1:0] xin;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [SAMPLE_BITS-1:0] y_next;
  logic signed [SAMPLE_BITS-1:0] lo;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      gx;
  logic signed [ACC_W-1:0]       acc;

  logic signed [STATE_BITS-1:0]  section_memory [DEPTH];
  logic [DEPTH-1:0]              mem_valid;
  logic signed [STATE_BITS-1:0]  rdata;
  logic                          rvalid;

  logic [AW-1:0]                 base;
  logic [AW-1:0]                 raddr;
  logic [AW-1:0]                 waddr;
  logic                          wen;
  logic signed [STATE_BITS-1:0]  wdata;

  logic signed [COEF_BITS-1:0]   mult_a;
  logic signed [SAMPLE_BITS-1:0] mult_b;
  logic signed [ACC_W-1:0]       m_ext;
  logic signed [ACC_W-1:0]       coef_m;
  logic signed [ACC_W-1:0]       prod_ext;
  logic signed [ACC_W-1:0]       gx_ext;
  logic signed [ACC_W-1:0]       y_sum;
  logic signed [ACC_W-1:0]       y_rnd;
  logic signed [ACC_W-1:0]       st_in;
  logic signed [WIDE_W-1:0]      st_wide;
  logic signed [SAMPLE_BITS:0]   band_sum;
  logic signed [SAMPLE_BITS-1:0] band_sat;
  logic                          ch_sel;
  int                            slot;

  assign ch_sel = (CHANNELS > 1) ? chan_r : 1'b0;

  always_comb begin
    slot  = int'(cmd.chain) * SLOTS + (int'(ch_sel) * MAX_STAGES + int'(stage_idx)) * 2;
    base  = AW'(slot);
    raddr = (cmd.step == STEP_OUT_Y) ? base + AW'(1) : base;
    waddr = (cmd.step == STEP_STATE2) ? base + AW'(1) : base;
    wen   = (cmd.step == STEP_STATE1) || (cmd.step == STEP_STATE2);
  end

  // Multiplier operands: gain times x, then the two feedback terms times y.
  always_comb begin
    case (cmd.step)
      STEP_READ:   mult_a = cmd.chain ? high_gain : low_gain;
      STEP_FB1:    mult_a = cmd.chain ? high_fb1 : low_fb1;
      STEP_STATE1: mult_a = cmd.chain ? high_fb2 : low_fb2;
      default:     mult_a = '0;
    endcase
    mult_b = (cmd.step == STEP_READ) ? x : y;
  end

  always_comb begin
    m_ext    = $signed({{(ACC_W - STATE_BITS){rdata[STATE_BITS-1]}}, rdata});
    if (!rvalid) begin
      m_ext = '0;
    end
    if (DN == 0) begin
      coef_m = m_ext <<< UP;
    end else begin
      coef_m = (m_ext + RND_DN) >>> DN;
    end
    prod_ext = $signed({{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod});
    gx_ext   = $signed({{(ACC_W - PROD_W){gx[PROD_W-1]}}, gx});

    y_sum = prod_ext + coef_m;
    y_rnd = (y_sum + RND_CF) >>> COEF_FRAC_BITS;
    if (y_rnd > Y_HI) begin
      y_next = Y_HI[SAMPLE_BITS-1:0];
    end else if (y_rnd < Y_LO) begin
      y_next = Y_LO[SAMPLE_BITS-1:0];
    end else begin
      y_next = y_rnd[SAMPLE_BITS-1:0];
    end

    st_in = (cmd.step == STEP_STATE1) ? acc - prod_ext : gx_ext - prod_ext;
    if (DN == 0) begin
      st_wide = WIDE_W'((st_in + RND_UP) >>> UP);
    end else begin
      st_wide = WIDE_W'(st_in) <<< DN;
    end
    if (st_wide > M_HI) begin
      wdata = M_HI[STATE_BITS-1:0];
    end else if (st_wide < M_LO) begin
      wdata = M_LO[STATE_BITS-1:0];
    end else begin
      wdata = st_wide[STATE_BITS-1:0];
    end

    band_sum = {lo[SAMPLE_BITS-1], lo} + {y[SAMPLE_BITS-1], y};
    if (band_sum > S_HI) begin
      band_sat = S_HI[SAMPLE_BITS-1:0];
    end else if (band_sum < S_LO) begin
      band_sat = S_LO[SAMPLE_BITS-1:0];
    end else begin
      band_sat = band_sum[SAMPLE_BITS-1:0];
    end
  end

  // Section state; entries never written read as zero.
  always_ff @(posedge clk) begin
    if (wen) begin
      section_memory[waddr] <= wdata;
    end
    rdata  <= section_memory[raddr];
    rvalid <= mem_valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
    end else if (wen) begin
      mem_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      chan_r <= channel_id;
      xin    <= sample_in;
      x      <= sample_in;
    end
    if ((cmd.step == STEP_READ) || (cmd.step == STEP_FB1) ||
        (cmd.step == STEP_STATE1)) begin
      prod <= mult_a * mult_b;
    end
    if (cmd.step == STEP_OUT_Y) begin
      gx <= prod;
      y  <= y_next;
    end
    if (cmd.step == STEP_FB1) begin
      acc <= (cmd.chain ? -(gx_ext <<< 1) : (gx_ext <<< 1)) + coef_m;
    end
    if (cmd.step == STEP_STATE2) begin
      if (cmd.to_high) begin
        lo <= y;
        x  <= band_mode ? xin : y;
      end else begin
        x <= y;
      end
    end
    if (cmd.finish) begin
      channel_out <= chan_r;
      sample_out  <= band_mode ? band_sat : y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule
`default_nettype wire

>>> hdl/cbbf_checker.sv
`default_nettype none
`include "cascaded_biquad_band_filter_top_macros.svh"
module cbbf_checker import cbbf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   channel_out,
  input wire logic [SAMPLE_BITS-1:0] sample_out
);

  // A request occupies the block: no second one in the next cycle.
  `CBBF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice")
  // Reset leaves the block idle with no result pending.
  `CBBF_ASSERT_ALWAYS(a_reset_idle, rst, !in_stall && !out_valid, "not idle after reset")
  `CBBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `CBBF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
    $stable(sample_out) && $stable(channel_out), "stalled result changed")

endmodule

bind cascaded_biquad_band_filter_top cbbf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cbbf_checker (.*);
`default_nettype wire

>>> tb/sv/cascaded_biquad_band_filter_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module cascaded_biquad_band_filter_top_tb;
  import cbbf_pkg::*;

  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam int NSTG  = MAX_STAGES_DEF;
  localparam int FRAC_SHIFT = COEF_FRAC_BITS_DEF - STATE_FRAC_BITS;
  localparam int SETTLE = 60;

  typedef struct {
    bit                      ch;
    logic signed [SBITS-1:0] smp;
  } audio_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic channel_id = 1'b0;
  logic signed [SBITS-1:0] sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic channel_out;
  logic signed [SBITS-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_BAND_MODE;
  logic [COEF_BITS-1:0] cfg_data = '0;

  cascaded_biquad_band_filter_top u_top (
    .clk, .rst, .in_valid, .in_stall, .channel_id, .sample_in,
    .out_valid, .out_stall, .channel_out, .sample_out,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // Shadow of the register file and the section memories.
  bit     mode_reject = 1'b0;
  int     stages_reg = 1;
  longint lo_gain = 0, lo_a1 = 0, lo_a2 = 0;
  longint hi_gain = 0, hi_a1 = 0, hi_a2 = 0;
  longint lo_mem [2*NSTG*2];
  longint hi_mem [2*NSTG*2];

  audio_req_t sample_backlog[$];
  audio_req_t filtered_q[$];
  int  err_count = 0;
  int  checked = 0;
  int  accepted = 0;
  bit  took_req = 1'b0;
  bit  no_idle = 1'b0;
  bit  drain_hold = 1'b0;
  int  send_gap = 0;
  int  stall_len = 0;

  initial begin
    foreach (lo_mem[i]) begin
      lo_mem[i] = 0;
      hi_mem[i] = 0;
    end
  end

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint biquad(bit hp, int base, longint x);
    longint g, a1, a2, m0, m1, gx, y, s1, s2;
    g  = hp ? hi_gain : lo_gain;
    a1 = hp ? hi_a1 : lo_a1;
    a2 = hp ? hi_a2 : lo_a2;
    m0 = hp ? hi_mem[base] : lo_mem[base];
    m1 = hp ? hi_mem[base+1] : lo_mem[base+1];
    gx = g * x;
    y  = clip(round_shift(gx + (m0 <<< FRAC_SHIFT), COEF_FRAC_BITS_DEF), SBITS);
    s1 = (hp ? -2 * gx : 2 * gx) - a1 * y + (m1 <<< FRAC_SHIFT);
    s2 = gx - a2 * y;
    s1 = clip(round_shift(s1, FRAC_SHIFT), STATE_BITS);
    s2 = clip(round_shift(s2, FRAC_SHIFT), STATE_BITS);
    if (hp) begin
      hi_mem[base] = s1;
      hi_mem[base+1] = s2;
    end else begin
      lo_mem[base] = s1;
      lo_mem[base+1] = s2;
    end
    return y;
  endfunction

  function automatic longint run_chain(bit hp, bit ch, int n, longint x);
    for (int s = 0; s < n; s++)
      x = biquad(hp, (ch * NSTG + s) * 2, x);
    return x;
  endfunction

  function automatic logic signed [SBITS-1:0] band_filter(bit ch, longint x);
    int n;
    longint lo, y;
    n = (stages_reg == 0) ? 1 : (stages_reg > NSTG ? NSTG : stages_reg);
    lo = run_chain(1'b0, ch, n, x);
    if (!mode_reject)
      y = run_chain(1'b1, ch, n, lo);
    else
      y = clip(lo + run_chain(1'b1, ch, n, x), SBITS);
    return y[SBITS-1:0];
  endfunction

  function automatic longint as_coef(logic [COEF_BITS-1:0] d);
    logic signed [COEF_BITS-1:0] s;
    s = d;
    return longint'(s);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Predict on acceptance, mirror register writes.
  always @(posedge clk) begin
    audio_req_t e;
    took_req <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      e.ch = channel_id;
      e.smp = band_filter(channel_id, longint'(sample_in));
      filtered_q.push_back(e);
      accepted++;
      if (accepted % 173 == 0) drain_hold <= 1'b1;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAND_MODE:   mode_reject = cfg_data[0];
        REG_STAGE_COUNT: stages_reg = int'(cfg_data[STAGE_CNT_BITS-1:0]);
        REG_LOW_GAIN:    lo_gain = as_coef(cfg_data);
        REG_LOW_FB1:     lo_a1 = as_coef(cfg_data);
        REG_LOW_FB2:     lo_a2 = as_coef(cfg_data);
        REG_HIGH_GAIN:   hi_gain = as_coef(cfg_data);
        REG_HIGH_FB1:    hi_a1 = as_coef(cfg_data);
        REG_HIGH_FB2:    hi_a2 = as_coef(cfg_data);
        default: ;
      endcase
    end
  end

  // Check each returned sample against the oldest prediction.
  always @(posedge clk) begin
    audio_req_t e;
    if (!rst && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: channel_out=%0d sample_out=%0d", channel_out, sample_out);
        err_count++;
      end else begin
        e = filtered_q.pop_front();
        checked++;
        if (channel_out !== e.ch) begin
          $error("channel_out: expected %0d, got %0d", e.ch, channel_out);
          err_count++;
        end
        if (sample_out !== e.smp) begin
          $error("sample_out: expected %0d, got %0d", e.smp, sample_out);
          err_count++;
        end
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_req) begin
      if (drain_hold && filtered_q.size() != 0) begin
        in_valid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        audio_req_t r;
        r = sample_backlog.pop_front();
        drain_hold <= 1'b0;
        in_valid <= 1'b1;
        channel_id <= r.ch;
        sample_in <= r.smp;
        send_gap <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure.
  always @(negedge clk) begin
    if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_stall <= 1'b1;
    end else begin
      stall_len <= idle_len();
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[COEF_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    wait (sample_backlog.size() == 0 && filtered_q.size() == 0);
    @(negedge clk);
    wait (!in_valid && filtered_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_filter(bit rej, int stg, longint lg, longint l1, longint l2,
                                longint hg, longint h1, longint h2);
    wait_quiet();
    write_reg(REG_BAND_MODE, rej);
    write_reg(REG_STAGE_COUNT, stg);
    write_reg(REG_LOW_GAIN, lg);
    write_reg(REG_LOW_FB1, l1);
    write_reg(REG_LOW_FB2, l2);
    write_reg(REG_HIGH_GAIN, hg);
    write_reg(REG_HIGH_FB1, h1);
    write_reg(REG_HIGH_FB2, h2);
  endtask

  task automatic program_random(bit rej, int stg);
    longint lg, l1, l2, hg, h1, h2;
    if ($urandom_range(0, 3) == 0) begin
      lg = longint'($signed($urandom)) % (1 << 24);
      l1 = longint'($signed($urandom)) % (1 << 24);
      l2 = longint'($signed($urandom)) % (1 << 24);
      hg = longint'($signed($urandom)) % (1 << 24);
      h1 = longint'($signed($urandom)) % (1 << 24);
      h2 = longint'($signed($urandom)) % (1 << 24);
    end else begin
      // plausible stable second-order sections
      lg = $urandom_range(1 << 10, 1 << 20);
      l2 = $urandom_range(1 << 21, 3984588);
      l1 = -longint'($urandom_range(1 << 21, 4194304 + l2 - 1));
      hg = $urandom_range(1 << 21, 4000000);
      h2 = $urandom_range(1 << 21, 3984588);
      h1 = -longint'($urandom_range(1 << 21, 4194304 + h2 - 1));
    end
    program_filter(rej, stg, lg, l1, l2, hg, h1, h2);
  endtask

  task automatic queue_sample(bit ch, longint x);
    audio_req_t r;
    r.ch = ch;
    r.smp = x[SBITS-1:0];
    sample_backlog.push_back(r);
  endtask

  task automatic queue_extremes();
    queue_sample(1'b0, 8388607);
    queue_sample(1'b1, -8388608);
    queue_sample(1'b0, -8388608);
    queue_sample(1'b1, 8388607);
    queue_sample(1'b0, 0);
    queue_sample(1'b1, -1);
  endtask

  initial begin
    int r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_filter(1'b0, 1, 300000, -6000000, 2600000, 3200000, -6000000, 2600000);
    queue_extremes();
    program_filter(1'b1, 4, 16777215, 16777215, 16777215, 16777215, 16777215, 16777215);
    queue_extremes();
    program_filter(1'b1, 0, -16777216, -16777216, -16777216, -16777216, -16777216,
                   -16777216);
    queue_extremes();
    program_filter(1'b0, 7, 16777215, -16777216, 16777215, -16777216, 16777215,
                   -16777216);
    queue_extremes();

    for (int ph = 0; ph < 14; ph++) begin
      program_random($urandom_range(0, 1), ph % 8);
      no_idle = (ph % 5 == 2);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          queue_sample($urandom_range(0, 1), $urandom_range(0, 1) ? 8388607 : -8388608);
        else if (r < 4)
          queue_sample($urandom_range(0, 1), longint'($signed($urandom)) % 4096);
        else
          queue_sample($urandom_range(0, 1), longint'($signed($urandom)) % (1 << 23));
      end
    end
    no_idle = 1'b0;

    wait_quiet();
    $display("Covered %0d requests, %0d results checked, across both band modes,",
             accepted, checked);
    $display("stage counts 0 to 7 and coefficient sets from extreme to stable.");
    if (err_count == 0 && filtered_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #8ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
